/* rtl/slx_pkg.sv */
// slx_pkg: shared types, token and mode codes, character constants for the
// s-expression lexer. no dependencies.
`default_nettype none

package slx_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 3;
   localparam int MODE_W = 2;

   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam logic [KIND_W-1:0] KIND_TEXT    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TEXTEND = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DQUOTE  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SQUOTE  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_END     = 3'd6;

   localparam logic [MODE_W-1:0] MODE_NORMAL  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SYMBOL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STRING  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_COMMENT = 2'd3;

   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
   localparam logic [CHAR_W-1:0] CH_NL     = 8'h0a;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NONE   = 8'h00;

   // one classified input transaction: one or two results
   typedef struct packed {
      logic              two;
      logic [KIND_W-1:0] kind0;
      logic [CHAR_W-1:0] char0;
      logic [KIND_W-1:0] kind1;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

/* rtl/slx_req_if.sv */
// slx_req_if: input channel of the lexer, one byte or an end mark.
// depends on slx_pkg.
`default_nettype none

interface slx_req_if import slx_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_byte;
   logic              end_of_input;

   modport source (output valid, output char_byte, output end_of_input, input ready);
   modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

/* rtl/slx_rsp_if.sv */
// slx_rsp_if: result channel of the lexer, one token per transaction.
// depends on slx_pkg.
`default_nettype none

interface slx_rsp_if import slx_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] token_kind;
   logic [CHAR_W-1:0] token_char;
   logic              last;

   modport source (output valid, output token_kind, output token_char, output last,
                   input ready);
   modport sink   (input valid, input token_kind, input token_char, input last,
                   output ready);
endinterface

`default_nettype wire

/* rtl/slx_front.sv */
// slx_front: accepts input transactions, keeps the lexer mode and classifies
// each byte into a command for the queue. depends on slx_pkg, slx_req_if.
`default_nettype none

module slx_front import slx_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   slx_req_if.sink               req_if,
   input  wire queue_status_type q_status,
   output logic                  push,
   output cmd_type               push_cmd
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              accept;
   logic              emit;
   logic              norm_emit;
   logic [KIND_W-1:0] norm_kind;
   logic [CHAR_W-1:0] norm_char;
   logic [MODE_W-1:0] norm_mode;
   logic              is_space;
   logic              is_term;
   logic [CHAR_W-1:0] c;
   logic              eoi;

   assign c      = req_if.char_byte;
   assign eoi    = req_if.end_of_input;
   assign accept = req_if.valid && !q_status.full;
   assign req_if.ready = !q_status.full;

   assign is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
   assign is_term  = (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_DQUOTE);

   // normal mode scan, also used for a symbol terminator
   always_comb begin
      norm_emit = 1'b1;
      norm_kind = KIND_TEXT;
      norm_char = CH_NONE;
      norm_mode = MODE_NORMAL;
      if (eoi) begin
         norm_kind = KIND_END;
      end else begin
         case (c)
            CH_SPACE, CH_TAB, CH_NL, CH_CR: begin
               norm_emit = 1'b0;
            end
            CH_LPAREN: begin
               norm_kind = KIND_LPAREN;
            end
            CH_RPAREN: begin
               norm_kind = KIND_RPAREN;
            end
            CH_SQUOTE: begin
               norm_kind = KIND_SQUOTE;
            end
            CH_DQUOTE: begin
               norm_kind = KIND_DQUOTE;
               norm_mode = MODE_STRING;
            end
            CH_SEMI: begin
               norm_emit = 1'b0;
               norm_mode = MODE_COMMENT;
            end
            default: begin
               norm_kind = KIND_TEXT;
               norm_char = c;
               norm_mode = MODE_SYMBOL;
            end
         endcase
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      emit           = 1'b0;
      push_cmd.two   = 1'b0;
      push_cmd.kind0 = KIND_TEXT;
      push_cmd.char0 = CH_NONE;
      push_cmd.kind1 = KIND_END;
      case (mode_ff)
         MODE_NORMAL: begin
            emit           = norm_emit;
            push_cmd.kind0 = norm_kind;
            push_cmd.char0 = norm_char;
            mode_in        = norm_mode;
         end
         MODE_SYMBOL: begin
            emit = 1'b1;
            if (!eoi && is_space) begin
               push_cmd.kind0 = KIND_TEXTEND;
               mode_in        = MODE_NORMAL;
            end else if (eoi || is_term) begin
               push_cmd.two   = 1'b1;
               push_cmd.kind0 = KIND_TEXTEND;
               push_cmd.kind1 = norm_kind;
               mode_in        = norm_mode;
            end else begin
               push_cmd.kind0 = KIND_TEXT;
               push_cmd.char0 = c;
            end
         end
         MODE_STRING: begin
            emit = 1'b1;
            if (eoi) begin
               push_cmd.two   = 1'b1;
               push_cmd.kind0 = KIND_TEXTEND;
               push_cmd.kind1 = KIND_END;
               mode_in        = MODE_NORMAL;
            end else if (c == CH_DQUOTE) begin
               push_cmd.two   = 1'b1;
               push_cmd.kind0 = KIND_TEXTEND;
               push_cmd.kind1 = KIND_DQUOTE;
               mode_in        = MODE_NORMAL;
            end else begin
               push_cmd.kind0 = KIND_TEXT;
               push_cmd.char0 = c;
            end
         end
         default: begin
            if (eoi) begin
               emit           = 1'b1;
               push_cmd.kind0 = KIND_END;
               mode_in        = MODE_NORMAL;
            end else if (c == CH_NL) begin
               mode_in = MODE_NORMAL;
            end
         end
      endcase
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/slx_queue.sv */
// slx_queue: small command fifo between front and back end.
// depends on slx_pkg.
`default_nettype none

module slx_queue import slx_pkg::*; #(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire cmd_type    push_cmd,
   input  wire logic       pop,
   output cmd_type         pop_cmd,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

/* rtl/slx_back.sv */
// slx_back: drains commands from the queue and emits one token per
// result transaction through an output register. depends on slx_pkg, slx_rsp_if.
`default_nettype none

module slx_back import slx_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   input  wire queue_status_type q_status,
   output logic                  pop,
   slx_rsp_if.source             rsp_if
);

   logic              valid_ff, valid_in;
   logic              phase_ff, phase_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic              load, take;

   assign load = !valid_ff || rsp_if.ready;
   assign take = load && !q_status.empty;
   assign pop  = take && (!cmd.two || phase_ff);

   always_comb begin
      valid_in = load ? !q_status.empty : valid_ff;
      phase_in = take ? (cmd.two && !phase_ff) : phase_ff;
      kind_in  = phase_ff ? cmd.kind1 : cmd.kind0;
      char_in  = phase_ff ? CH_NONE : cmd.char0;
      last_in  = !cmd.two || phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff <= kind_in;
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.token_kind = kind_ff;
   assign rsp_if.token_char = char_ff;
   assign rsp_if.last       = last_ff;

endmodule

`default_nettype wire

/* rtl/sexpr_lexer_unit.sv */
// sexpr_lexer_unit: top level of the s-expression lexer, front end, command
// queue and back end. depends on slx_pkg, slx_req_if, slx_rsp_if and submodules.
//
//   channel  dir  payload                          transaction
//   req_if   in   char_byte, end_of_input          valid && ready
//   rsp_if   out  token_kind, token_char, last     valid && ready
//
// one input byte per cycle while rsp ready stays high and each byte gives at most
// one token; a byte giving two tokens holds the back end output register for both.
// a token reaches rsp_if from its accepted byte through the queue, then the output register.
// the queue of QUEUE_DEPTH commands lets the input keep going while the
// output stalls; req ready drops only when the queue is full.
// reset puts the lexer in normal mode and empties queue and output register.
`default_nettype none

module sexpr_lexer_unit import slx_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   slx_req_if.sink   req_if,
   slx_rsp_if.source rsp_if
);

   logic             push, pop;
   cmd_type          push_cmd, pop_cmd;
   queue_status_type q_status;

   slx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   slx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   slx_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd      (pop_cmd),
      .q_status (q_status),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

   // only the first of a token pair is not last, and it is always a text end
   a_pair_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.last) |-> (rsp_if.token_kind == KIND_TEXTEND))
      else $error("non-last token is not a text end");

   // only text tokens carry a character
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.token_kind != KIND_TEXT)) |-> (rsp_if.token_char == CH_NONE))
      else $error("non-text token carries a character");

   // queue status is consistent and drives input backpressure
   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty) && (req_if.ready == !q_status.full))
      else $error("queue status inconsistent");

   // a pop happens only while the queue holds a command
   a_pop_only_filled: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire
